// ===== rtl/idra_pkg.sv =====
// idra_pkg: shared types and codes for the ID recycling allocator.
// No dependencies; imported by the controller, datapath and top level.
package idra_pkg;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } idra_ctrl_t;

endpackage

// ===== rtl/id_recycling_allocator_core.sv =====
// id_recycling_allocator_core: top level of the ID recycling allocator.
// Depends on idra_pkg, idra_ctrl and idra_dp.

// A request (allocate or release) is taken when start is high and busy is low.
// Each request is handled in two steps: the head of the free-ID ring memory is
// read into a register at accept, then the exec state updates the pointers and
// counters. Its single result appears with done high for exactly one cycle,
// registered at the end of the exec state, and cannot be held off; a new request
// may be accepted during that done cycle, but not while busy is high in exec.
// fresh_count and free_count show the state after the last completed request
// and hold until the next one completes. The ring memory needs no clearing
// after reset.
module id_recycling_allocator_core
    import idra_pkg::*;
#(
    parameter int ID_BITS    = 16,
    parameter int FREE_DEPTH = 256
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            cmd,
    input  logic [ID_BITS-1:0]              released_id,
    output logic                            done,
    output logic [ID_BITS-1:0]              given_id,
    output logic [1:0]                      status,
    output logic [ID_BITS:0]                fresh_count,
    output logic [$clog2(FREE_DEPTH+1)-1:0] free_count
);

    idra_ctrl_t ctrl;

    idra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    idra_dp #(
        .ID_BITS    (ID_BITS),
        .FREE_DEPTH (FREE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cmd         (cmd),
        .released_id (released_id),
        .done        (done),
        .given_id    (given_id),
        .status      (status),
        .fresh_count (fresh_count),
        .free_count  (free_count)
    );

endmodule

// ===== rtl/idra_ctrl.sv =====
// idra_ctrl: request sequencer for the ID recycling allocator.
// Depends on idra_pkg; drives the idra_dp command struct.
module idra_ctrl
    import idra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output idra_ctrl_t ctrl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy      = (state_reg == S_EXEC);
    assign ctrl.load = (state_reg == S_IDLE) && start;
    assign ctrl.exec = (state_reg == S_EXEC);

`ifndef SYNTH
    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> ctrl.exec)
        else $error("exec did not follow load");
    a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec |=> !ctrl.exec)
        else $error("exec held for more than one cycle");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.load && ctrl.exec))
        else $error("load during exec");
`endif

endmodule

// ===== rtl/idra_dp.sv =====
// idra_dp: free-ID ring memory, head/tail/fill pointers, fresh counter, result registers.
// Depends on idra_pkg; sequenced by idra_ctrl.
module idra_dp
    import idra_pkg::*;
#(
    parameter int ID_BITS    = 16,
    parameter int FREE_DEPTH = 256
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  idra_ctrl_t                      ctrl,
    input  logic                            cmd,
    input  logic [ID_BITS-1:0]              released_id,
    output logic                            done,
    output logic [ID_BITS-1:0]              given_id,
    output logic [1:0]                      status,
    output logic [ID_BITS:0]                fresh_count,
    output logic [$clog2(FREE_DEPTH+1)-1:0] free_count
);

    localparam int AW = $clog2(FREE_DEPTH);
    localparam int CW = $clog2(FREE_DEPTH + 1);

    logic [ID_BITS-1:0] mem [FREE_DEPTH];

    logic               cmd_reg;
    logic [ID_BITS-1:0] rel_reg;
    logic [ID_BITS-1:0] rd_data_reg;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [ID_BITS:0]   fresh_reg, fresh_next;
    logic [ID_BITS-1:0] given_reg, given_next;
    logic [1:0]         status_reg, status_next;
    logic               done_reg;
    logic               wr_en;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] pos);
        logic [AW-1:0] res;
        if (pos == AW'(FREE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = pos + 1'b1;
        end
        return res;
    endfunction

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        fresh_next  = fresh_reg;
        given_next  = '0;
        status_next = ST_OK;
        wr_en       = 1'b0;
        if (ctrl.exec)
        begin
            if (cmd_reg == CMD_ALLOC)
            begin
                if (fill_reg != '0)
                begin
                    given_next = rd_data_reg;
                    head_next  = ring_inc(head_reg);
                    fill_next  = fill_reg - 1'b1;
                end
                else if (!fresh_reg[ID_BITS])
                begin
                    given_next = fresh_reg[ID_BITS-1:0];
                    fresh_next = fresh_reg + 1'b1;
                end
                else
                begin
                    status_next = ST_EXHAUSTED;
                end
            end
            else
            begin
                if (fill_reg == CW'(FREE_DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    tail_next = ring_inc(tail_reg);
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
    end

    // ring storage; read is issued at accept, used in the exec cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= rel_reg;
        end
        if (ctrl.load)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
            rel_reg <= released_id;
        end
        if (ctrl.exec)
        begin
            given_reg  <= given_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            fresh_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            fresh_reg <= fresh_next;
            done_reg  <= ctrl.exec;
        end
    end

    assign done        = done_reg;
    assign given_id    = given_reg;
    assign status      = status_reg;
    assign fresh_count = fresh_reg;
    assign free_count  = fill_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(FREE_DEPTH))
        else $error("free queue fill beyond depth");
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !(fresh_reg[ID_BITS] && (fresh_reg[ID_BITS-1:0] != '0)))
        else $error("fresh counter beyond ID space");
    a_done_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec |=> done_reg)
        else $error("no result after exec");
    a_full_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_FULL) |-> $past(cmd_reg) == CMD_RELEASE)
        else $error("full status on an allocate");
    a_error_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_OK) |-> given_reg == '0)
        else $error("nonzero ID on error");
`endif

endmodule

// ===== dv/idra_result_checker.sv =====
// idra_result_checker: predicts and checks every result of the ID recycling allocator.
// Watches the start/busy request channel and the done strobe; depends on idra_pkg.
// Reports a running failure count and the number of results still owed.
module idra_result_checker
    import idra_pkg::*;
#(
    parameter int ID_BITS    = 16,
    parameter int FREE_DEPTH = 256
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            cmd,
    input  logic [ID_BITS-1:0]              released_id,
    input  logic                            done,
    input  logic [ID_BITS-1:0]              given_id,
    input  logic [1:0]                      status,
    input  logic [ID_BITS:0]                fresh_count,
    input  logic [$clog2(FREE_DEPTH+1)-1:0] free_count,
    output int                              fail_count,
    output int                              owed
);

    localparam int FILL_W = $clog2(FREE_DEPTH+1);

    typedef struct packed {
        logic [ID_BITS-1:0] given_id;
        logic [1:0]         status;
        logic [ID_BITS:0]   fresh_count;
        logic [FILL_W-1:0]  free_count;
    } id_result_t;

    logic [ID_BITS-1:0] free_ring [FREE_DEPTH];
    int                 ring_head;
    int                 ring_tail;
    int                 ring_fill;
    logic [ID_BITS:0]   fresh_issued;
    id_result_t         owed_results [$];
    id_result_t         due_result;

    // advances the shadow allocator by one request and returns its result
    function automatic id_result_t serve_request(logic op, logic [ID_BITS-1:0] id);
        id_result_t r;
        r = '0;
        r.status = ST_OK;
        if (op == CMD_ALLOC) begin
            if (ring_fill > 0) begin
                r.given_id = free_ring[ring_head];
                ring_head  = (ring_head + 1) % FREE_DEPTH;
                ring_fill--;
            end
            else if (fresh_issued[ID_BITS] == 1'b0) begin
                r.given_id   = fresh_issued[ID_BITS-1:0];
                fresh_issued = fresh_issued + 1'b1;
            end
            else begin
                r.status = ST_EXHAUSTED;
            end
        end
        else begin
            if (ring_fill >= FREE_DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                free_ring[ring_tail] = id;
                ring_tail = (ring_tail + 1) % FREE_DEPTH;
                ring_fill++;
            end
        end
        r.fresh_count = fresh_issued;
        r.free_count  = FILL_W'(ring_fill);
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ring_head    = 0;
            ring_tail    = 0;
            ring_fill    = 0;
            fresh_issued = '0;
            fail_count   = 0;
            owed_results.delete();
            owed <= 0;
        end
        else begin
            if (done) begin
                if (owed_results.size() == 0) begin
                    $error("result strobe with no item outstanding");
                    fail_count++;
                end
                else begin
                    due_result = owed_results.pop_front();
                    check_field("given_id", due_result.given_id, given_id);
                    check_field("status", due_result.status, status);
                    check_field("fresh_count", due_result.fresh_count, fresh_count);
                    check_field("free_count", due_result.free_count, free_count);
                end
            end
            if (start && !busy) begin
                owed_results.push_back(serve_request(cmd, released_id));
            end
            owed <= owed_results.size();
        end
    end

endmodule

// ===== dv/id_recycling_allocator_core_tb.sv =====
// id_recycling_allocator_core_tb: stimulus and verdict for the ID recycling allocator.
// Depends on idra_pkg, id_recycling_allocator_core and idra_result_checker.
module id_recycling_allocator_core_tb;
    import idra_pkg::*;

    localparam int ID_BITS        = 16;
    localparam int FREE_DEPTH     = 256;
    localparam int FILL_W         = $clog2(FREE_DEPTH+1);
    localparam int WATCHDOG_LIMIT = 1000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                cmd;
    logic [ID_BITS-1:0]  released_id;
    logic                done;
    logic [ID_BITS-1:0]  given_id;
    logic [1:0]          status;
    logic [ID_BITS:0]    fresh_count;
    logic [FILL_W-1:0]   free_count;
    int                  fail_count;
    int                  owed;
    int                  quiet_cycles = 0;
    int                  burst_left = 0;

    always #5 clk = ~clk;

    id_recycling_allocator_core #(
        .ID_BITS    (ID_BITS),
        .FREE_DEPTH (FREE_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .released_id (released_id),
        .done        (done),
        .given_id    (given_id),
        .status      (status),
        .fresh_count (fresh_count),
        .free_count  (free_count)
    );

    idra_result_checker #(
        .ID_BITS    (ID_BITS),
        .FREE_DEPTH (FREE_DEPTH)
    ) result_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .released_id (released_id),
        .done        (done),
        .given_id    (given_id),
        .status      (status),
        .fresh_count (fresh_count),
        .free_count  (free_count),
        .fail_count  (fail_count),
        .owed        (owed)
    );

    always @(posedge clk) begin
        if ((start && !busy) || done) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // bursts of back-to-back items separated by random gaps
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk) start <= 1'b0;
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    task automatic issue(logic op, logic [ID_BITS-1:0] id);
        pace();
        @(negedge clk);
        start       <= 1'b1;
        cmd         <= op;
        released_id <= id;
        @(posedge clk iff !busy);
    endtask

    function automatic logic [ID_BITS-1:0] rand_released_id();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return ID_BITS'($urandom_range(0, 15));
            default: return ID_BITS'($urandom);
        endcase
    endfunction

    task automatic run_mix(int count, int release_pct);
        logic op;
        repeat (count) begin
            op = ($urandom_range(0, 99) < release_pct) ? CMD_RELEASE : CMD_ALLOC;
            issue(op, rand_released_id());
        end
    endtask

    initial begin
        start       = 1'b0;
        cmd         = CMD_ALLOC;
        released_id = '0;
        rst_n       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // fresh IDs, then recycling in release order, duplicates and foreign IDs
        issue(CMD_ALLOC, '1);
        issue(CMD_ALLOC, '0);
        issue(CMD_ALLOC, 16'h1234);
        issue(CMD_RELEASE, '0);
        issue(CMD_RELEASE, '1);
        issue(CMD_RELEASE, 16'h0001);
        issue(CMD_RELEASE, 16'h1234);
        issue(CMD_RELEASE, '1);
        repeat (6) issue(CMD_ALLOC, '0);
        issue(CMD_RELEASE, 16'hAAAA);
        issue(CMD_RELEASE, 16'h5555);
        issue(CMD_ALLOC, '1);
        issue(CMD_ALLOC, '1);
        issue(CMD_ALLOC, '0);

        // fill past full, drain with mostly allocates, then mixed traffic
        run_mix(350, 90);
        run_mix(250, 10);
        run_mix(200, 75);
        run_mix(200, 40);

        // short release and allocate tail
        issue(CMD_RELEASE, 16'h00FF);
        issue(CMD_RELEASE, '1);
        issue(CMD_RELEASE, '0);
        repeat (5) issue(CMD_ALLOC, '0);
        issue(CMD_RELEASE, 16'h8001);
        issue(CMD_ALLOC, '0);
        issue(CMD_ALLOC, '0);

        @(negedge clk) start <= 1'b0;
        while (owed != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && owed == 0) begin
            $display("TEST PASSED");
        end
        else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
